@@ design/cbpd_pkg.sv @@
// ----------------------------------------------------------------------------
// Cascaded balance PID drive package
// Shared widths, constants, unit request types and small helper functions.
// ----------------------------------------------------------------------------
`default_nettype none

package cbpd_pkg;

   localparam int DW = 48;
   localparam int GW = 16;
   localparam int VW = 20;

   localparam int TICK_MS_DEF   = 10;
   localparam int COUNT_MAX_DEF = 1023;
   localparam int SPEED_K       = 3568715;
   localparam int Q16_FRAC      = 16;
   localparam int VOLT_MAX      = 12;

   localparam logic signed [DW-1:0] SAT_HI   = DW'(2147483647);
   localparam logic signed [DW-1:0] SAT_LO   = ~SAT_HI;
   localparam logic signed [DW-1:0] INTEG_HI = DW'(655360);
   localparam logic signed [DW-1:0] INTEG_LO = -INTEG_HI;

   localparam logic [3:0] SH_NONE = 4'd0;
   localparam logic [3:0] SH_Q88  = 4'd8;
   localparam logic [3:0] SH_Q412 = 4'd12;

   localparam logic [3:0] CSR_ANGLE_KP  = 4'd0;
   localparam logic [3:0] CSR_ANGLE_KI  = 4'd1;
   localparam logic [3:0] CSR_ANGLE_KD  = 4'd2;
   localparam logic [3:0] CSR_SPEED_KP  = 4'd3;
   localparam logic [3:0] CSR_SPEED_KI  = 4'd4;
   localparam logic [3:0] CSR_SPEED_KD  = 4'd5;
   localparam logic [3:0] CSR_TILT_GAIN = 4'd6;
   localparam logic [3:0] CSR_FB_GAIN   = 4'd7;

   typedef struct packed {
      logic                 start;
      logic signed [DW-1:0] a;
      logic [GW-1:0]        g;
      logic [3:0]           sh;
   } mul_req_type;

   typedef struct packed {
      logic                 start;
      logic signed [DW-1:0] a;
      logic [VW-1:0]        divisor;
   } div_req_type;

   function automatic logic signed [DW-1:0] sat32(input logic signed [DW-1:0] x);
      logic signed [DW-1:0] r;
      r = x;
      if (x > SAT_HI) r = SAT_HI;
      if (x < SAT_LO) r = SAT_LO;
      return r;
   endfunction

   function automatic logic [7:0] right_duty(input logic [3:0] v);
      logic [7:0] r;
      unique case (v)
         4'd0:  r = 8'd0;
         4'd1:  r = 8'd21;
         4'd2:  r = 8'd42;
         4'd3:  r = 8'd63;
         4'd4:  r = 8'd85;
         4'd5:  r = 8'd106;
         4'd6:  r = 8'd127;
         4'd7:  r = 8'd148;
         4'd8:  r = 8'd170;
         4'd9:  r = 8'd191;
         4'd10: r = 8'd212;
         4'd11: r = 8'd233;
         default: r = 8'd255;
      endcase
      return r;
   endfunction

   function automatic logic [7:0] left_duty(input logic [3:0] v);
      logic [7:0] r;
      unique case (v)
         4'd0:  r = 8'd0;
         4'd1:  r = 8'd20;
         4'd2:  r = 8'd41;
         4'd3:  r = 8'd61;
         4'd4:  r = 8'd83;
         4'd5:  r = 8'd103;
         4'd6:  r = 8'd124;
         4'd7:  r = 8'd145;
         4'd8:  r = 8'd166;
         4'd9:  r = 8'd187;
         4'd10: r = 8'd207;
         4'd11: r = 8'd228;
         default: r = 8'd249;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

@@ design/cbpd_serial_mul.sv @@
// ----------------------------------------------------------------------------
// Serial multiplier
// Sign-magnitude shift-add multiply, one gain bit per cycle, with a final
// right shift truncating toward zero.
// ----------------------------------------------------------------------------
`default_nettype none

module cbpd_serial_mul import cbpd_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  mul_req_type          req,
   output logic                 done,
   output logic signed [DW-1:0] result
);

   localparam int AW = DW + GW;
   localparam int CW = $clog2(GW + 1);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic          neg_ff, neg_in;
   logic [3:0]    sh_ff, sh_in;
   logic [GW-1:0] g_ff, g_in;
   logic [AW-1:0] mcand_ff, mcand_in;
   logic [AW-1:0] acc_ff, acc_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [DW-1:0] mag;
   logic [AW-1:0] shifted;

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      neg_in   = neg_ff;
      sh_in    = sh_ff;
      g_in     = g_ff;
      mcand_in = mcand_ff;
      acc_in   = acc_ff;
      cnt_in   = cnt_ff;
      mag      = req.a[DW-1] ? DW'(-req.a) : DW'(req.a);
      if (req.start) begin
         busy_in  = 1'b1;
         neg_in   = req.a[DW-1];
         sh_in    = req.sh;
         g_in     = req.g;
         mcand_in = AW'(mag);
         acc_in   = '0;
         cnt_in   = CW'(GW);
      end else if (busy_ff) begin
         if (g_ff[0]) begin
            acc_in = acc_ff + mcand_ff;
         end
         mcand_in = mcand_ff << 1;
         g_in     = g_ff >> 1;
         cnt_in   = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      neg_ff   <= neg_in;
      sh_ff    <= sh_in;
      g_ff     <= g_in;
      mcand_ff <= mcand_in;
      acc_ff   <= acc_in;
      cnt_ff   <= cnt_in;
   end

   assign shifted = acc_ff >> sh_ff;
   assign result  = neg_ff ? -$signed(shifted[DW-1:0]) : $signed(shifted[DW-1:0]);
   assign done    = done_ff;

endmodule

`default_nettype wire

@@ design/cbpd_serial_div.sv @@
// ----------------------------------------------------------------------------
// Serial divider
// Restoring division, one quotient bit per cycle, truncating toward zero.
// ----------------------------------------------------------------------------
`default_nettype none

module cbpd_serial_div import cbpd_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  div_req_type          req,
   output logic                 done,
   output logic signed [DW-1:0] result
);

   localparam int CW = $clog2(DW + 1);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic          neg_ff, neg_in;
   logic [VW-1:0] dvs_ff, dvs_in;
   logic [VW-1:0] rem_ff, rem_in;
   logic [DW-1:0] q_ff, q_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [VW:0]   trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      neg_in  = neg_ff;
      dvs_in  = dvs_ff;
      rem_in  = rem_ff;
      q_in    = q_ff;
      cnt_in  = cnt_ff;
      trial   = {rem_ff, q_ff[DW-1]};
      if (req.start) begin
         busy_in = 1'b1;
         neg_in  = req.a[DW-1];
         dvs_in  = req.divisor;
         rem_in  = '0;
         q_in    = req.a[DW-1] ? DW'(-req.a) : DW'(req.a);
         cnt_in  = CW'(DW);
      end else if (busy_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = VW'(trial - {1'b0, dvs_ff});
            q_in   = {q_ff[DW-2:0], 1'b1};
         end else begin
            rem_in = trial[VW-1:0];
            q_in   = {q_ff[DW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      neg_ff <= neg_in;
      dvs_ff <= dvs_in;
      rem_ff <= rem_in;
      q_ff   <= q_in;
      cnt_ff <= cnt_in;
   end

   assign result = neg_ff ? -$signed(q_ff) : $signed(q_ff);
   assign done   = done_ff;

endmodule

`default_nettype wire

@@ design/cascaded_balance_pid_drive_top.sv @@
// ----------------------------------------------------------------------------
// Cascaded balance PID drive
// Angle PID with speed compensation feeding a speed PID, then voltage and
// PWM mapping, computed by a sequencer over a serial multiplier and divider.
//
//   Channel  Direction  Handshake          Payload
//   req      in         valid / stall      roll_angle, left_count, right_count
//   rsp      out        valid / stall      left_pwm, right_pwm, forward
//   csr      in         valid / ready      index, data
//
// An item takes 14 multiplies on the shift-add multiplier and 6 divisions on the
// restoring divider, one after another, followed by the hold state and then the idle state.
// Reset is synchronous, restores the gains and clears the PID state; req is stalled
// and csr is not ready during reset, and csr is ready only while no item is computed.
// A finished result waits in the output register while rsp is stalled; a new item is
// accepted meanwhile and stalls only at its end if that result is still not taken.
// ----------------------------------------------------------------------------
`default_nettype none

module cascaded_balance_pid_drive_top import cbpd_pkg::*; #(
   parameter int TICK_MS   = TICK_MS_DEF,
   parameter int COUNT_MAX = COUNT_MAX_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [16:0] req_roll_angle,
   input  logic [9:0]         req_left_count,
   input  logic [9:0]         req_right_count,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [7:0]         rsp_left_pwm,
   output logic [7:0]         rsp_right_pwm,
   output logic               rsp_forward,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [3:0]         csr_index,
   input  logic [15:0]        csr_data
);

   localparam logic [16:0]   CMAX      = 17'(COUNT_MAX);
   localparam logic [VW-1:0] DIV_SPEED = VW'(TICK_MS * 512);
   localparam logic [VW-1:0] DIV_MS    = VW'(1000);
   localparam logic [VW-1:0] DIV_TICK  = VW'(TICK_MS);
   localparam logic [VW-1:0] DIV_THREE = VW'(3);
   localparam logic [GW-1:0] G_TICK    = GW'(TICK_MS);
   localparam logic [GW-1:0] G_MS      = GW'(1000);
   localparam logic [GW-1:0] G_TEN     = GW'(10);

   localparam logic [3:0] OP_SPD_MUL = 4'd0;
   localparam logic [3:0] OP_SPD_DIV = 4'd1;
   localparam logic [3:0] OP_ERR_MUL = 4'd2;
   localparam logic [3:0] OP_INT_MUL = 4'd3;
   localparam logic [3:0] OP_INT_DIV = 4'd4;
   localparam logic [3:0] OP_DER_MUL = 4'd5;
   localparam logic [3:0] OP_DER_DIV = 4'd6;
   localparam logic [3:0] OP_P_MUL   = 4'd7;
   localparam logic [3:0] OP_I_MUL   = 4'd8;
   localparam logic [3:0] OP_D_MUL   = 4'd9;
   localparam logic [3:0] OP_V_MUL   = 4'd10;
   localparam logic [3:0] OP_V_DIV   = 4'd11;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_ISSUE = 4'b0010,
      ST_WAIT  = 4'b0100,
      ST_HOLD  = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic [3:0] step_ff, step_in;
   logic       phase_ff, phase_in;

   logic [15:0] angle_kp_ff, angle_ki_ff, angle_kd_ff;
   logic [15:0] speed_kp_ff, speed_ki_ff, speed_kd_ff;
   logic [15:0] tilt_gain_ff, fb_gain_ff;

   logic signed [16:0]   roll_ff, roll_in;
   logic [10:0]          sum_ff, sum_in;
   logic signed [DW-1:0] tmp_ff, tmp_in;
   logic signed [DW-1:0] speed_ff, speed_in;
   logic signed [31:0]   e_ff, e_in;
   logic signed [31:0]   i_ff, i_in;
   logic signed [DW-1:0] d_ff, d_in;
   logic signed [DW-1:0] acc_ff, acc_in;
   logic signed [31:0]   target_ff, target_in;
   logic signed [31:0]   cmd_ff, cmd_in;
   logic signed [DW-1:0] vq_ff, vq_in;
   logic signed [31:0]   angle_integ_ff, angle_integ_in;
   logic signed [31:0]   angle_prev_ff, angle_prev_in;
   logic signed [31:0]   speed_integ_ff, speed_integ_in;
   logic signed [31:0]   speed_prev_ff, speed_prev_in;

   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_left_ff, rsp_left_in;
   logic [7:0] rsp_right_ff, rsp_right_in;
   logic       rsp_fwd_ff, rsp_fwd_in;

   mul_req_type          mul_req;
   div_req_type          div_req;
   logic                 mul_done, div_done;
   logic signed [DW-1:0] mul_res, div_res;

   logic                 accept, load;
   logic                 is_div, unit_done;
   logic signed [DW-1:0] r;
   logic signed [DW-1:0] ang256;
   logic [9:0]           lc_sat, rc_sat;
   logic [3:0]           volts;

   cbpd_serial_mul u_mul (
      .clock  (clock),
      .reset  (reset),
      .req    (mul_req),
      .done   (mul_done),
      .result (mul_res)
   );

   cbpd_serial_div u_div (
      .clock  (clock),
      .reset  (reset),
      .req    (div_req),
      .done   (div_done),
      .result (div_res)
   );

   assign csr_ready = !reset && (state_ff == ST_IDLE);
   assign req_stall = reset || (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign load      = (state_ff == ST_HOLD) && (!rsp_valid_ff || !rsp_stall);
   assign ang256    = DW'(roll_ff) <<< 8;
   assign lc_sat    = ({7'd0, req_left_count} > CMAX) ? CMAX[9:0] : req_left_count;
   assign rc_sat    = ({7'd0, req_right_count} > CMAX) ? CMAX[9:0] : req_right_count;
   assign is_div    = (step_ff == OP_SPD_DIV) || (step_ff == OP_INT_DIV) ||
                      (step_ff == OP_DER_DIV) || (step_ff == OP_V_DIV);
   assign unit_done = is_div ? div_done : mul_done;
   assign r         = is_div ? div_res : mul_res;
   assign volts     = (vq_ff[DW-1:Q16_FRAC] > (DW - Q16_FRAC)'(VOLT_MAX)) ?
                      4'(VOLT_MAX) : vq_ff[Q16_FRAC+3:Q16_FRAC];

   always_comb begin
      mul_req = '0;
      div_req = '0;
      if (state_ff == ST_ISSUE) begin
         unique case (step_ff)
            OP_SPD_MUL: mul_req = '{1'b1, DW'(SPEED_K), GW'(sum_ff), SH_NONE};
            OP_SPD_DIV: div_req = '{1'b1, tmp_ff, DIV_SPEED};
            OP_ERR_MUL: mul_req = '{1'b1, speed_ff,
                                    phase_ff ? fb_gain_ff : tilt_gain_ff, SH_Q88};
            OP_INT_MUL: mul_req = '{1'b1, DW'(e_ff), G_TICK, SH_NONE};
            OP_INT_DIV: div_req = '{1'b1, tmp_ff, DIV_MS};
            OP_DER_MUL: mul_req = '{1'b1, DW'(e_ff) -
                                    DW'(phase_ff ? speed_prev_ff : angle_prev_ff),
                                    G_MS, SH_NONE};
            OP_DER_DIV: div_req = '{1'b1, tmp_ff, DIV_TICK};
            OP_P_MUL:   mul_req = '{1'b1, DW'(e_ff),
                                    phase_ff ? speed_kp_ff : angle_kp_ff, SH_Q412};
            OP_I_MUL:   mul_req = '{1'b1, DW'(i_ff),
                                    phase_ff ? speed_ki_ff : angle_ki_ff, SH_Q412};
            OP_D_MUL:   mul_req = '{1'b1, d_ff,
                                    phase_ff ? speed_kd_ff : angle_kd_ff, SH_Q412};
            OP_V_MUL:   mul_req = '{1'b1, cmd_ff[31] ? -DW'(cmd_ff) : DW'(cmd_ff),
                                    G_TEN, SH_NONE};
            OP_V_DIV:   div_req = '{1'b1, tmp_ff, DIV_THREE};
            default: begin
               mul_req = '0;
               div_req = '0;
            end
         endcase
      end
   end

   always_comb begin
      logic signed [DW-1:0] err;
      logic signed [DW-1:0] isum;
      logic signed [DW-1:0] sum;
      state_in       = state_ff;
      step_in        = step_ff;
      phase_in       = phase_ff;
      roll_in        = roll_ff;
      sum_in         = sum_ff;
      tmp_in         = tmp_ff;
      speed_in       = speed_ff;
      e_in           = e_ff;
      i_in           = i_ff;
      d_in           = d_ff;
      acc_in         = acc_ff;
      target_in      = target_ff;
      cmd_in         = cmd_ff;
      vq_in          = vq_ff;
      angle_integ_in = angle_integ_ff;
      angle_prev_in  = angle_prev_ff;
      speed_integ_in = speed_integ_ff;
      speed_prev_in  = speed_prev_ff;
      err  = phase_ff ? (DW'(target_ff) - r) : (r - ang256);
      isum = DW'(phase_ff ? speed_integ_ff : angle_integ_ff) + r;
      if (isum > INTEG_HI) isum = INTEG_HI;
      if (isum < INTEG_LO) isum = INTEG_LO;
      sum  = sat32(acc_ff + r);
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               roll_in  = req_roll_angle;
               sum_in   = {1'b0, lc_sat} + {1'b0, rc_sat};
               phase_in = 1'b0;
               step_in  = OP_SPD_MUL;
               state_in = ST_ISSUE;
            end
         end
         ST_ISSUE: begin
            state_in = ST_WAIT;
         end
         ST_WAIT: begin
            if (unit_done) begin
               step_in  = step_ff + 4'd1;
               state_in = ST_ISSUE;
               unique case (step_ff)
                  OP_SPD_DIV: speed_in = r;
                  OP_ERR_MUL: e_in = 32'(sat32(err));
                  OP_INT_DIV: begin
                     i_in = 32'(isum);
                     if (phase_ff) speed_integ_in = 32'(isum);
                     else angle_integ_in = 32'(isum);
                  end
                  OP_DER_DIV: begin
                     d_in = r;
                     if (phase_ff) speed_prev_in = e_ff;
                     else angle_prev_in = e_ff;
                  end
                  OP_P_MUL: acc_in = r;
                  OP_I_MUL: acc_in = acc_ff + r;
                  OP_D_MUL: begin
                     if (phase_ff) begin
                        cmd_in  = 32'(sum);
                        step_in = OP_V_MUL;
                     end else begin
                        target_in = 32'(sum);
                        phase_in  = 1'b1;
                        step_in   = OP_ERR_MUL;
                     end
                  end
                  OP_V_DIV: begin
                     vq_in    = r;
                     state_in = ST_HOLD;
                  end
                  default: tmp_in = r;
               endcase
            end
         end
         ST_HOLD: begin
            if (load) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_left_in  = rsp_left_ff;
      rsp_right_in = rsp_right_ff;
      rsp_fwd_in   = rsp_fwd_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
         rsp_left_in  = left_duty(volts);
         rsp_right_in = right_duty(volts);
         rsp_fwd_in   = (cmd_ff > 32'sd0);
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         step_ff        <= OP_SPD_MUL;
         phase_ff       <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         angle_integ_ff <= '0;
         angle_prev_ff  <= '0;
         speed_integ_ff <= '0;
         speed_prev_ff  <= '0;
         angle_kp_ff    <= 16'd4710;
         angle_ki_ff    <= 16'd28672;
         angle_kd_ff    <= 16'd205;
         speed_kp_ff    <= 16'd614;
         speed_ki_ff    <= 16'd4;
         speed_kd_ff    <= 16'd4;
         tilt_gain_ff   <= 16'd3840;
         fb_gain_ff     <= 16'd8960;
      end else begin
         state_ff       <= state_in;
         step_ff        <= step_in;
         phase_ff       <= phase_in;
         rsp_valid_ff   <= rsp_valid_in;
         angle_integ_ff <= angle_integ_in;
         angle_prev_ff  <= angle_prev_in;
         speed_integ_ff <= speed_integ_in;
         speed_prev_ff  <= speed_prev_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_ANGLE_KP:  angle_kp_ff  <= csr_data;
               CSR_ANGLE_KI:  angle_ki_ff  <= csr_data;
               CSR_ANGLE_KD:  angle_kd_ff  <= csr_data;
               CSR_SPEED_KP:  speed_kp_ff  <= csr_data;
               CSR_SPEED_KI:  speed_ki_ff  <= csr_data;
               CSR_SPEED_KD:  speed_kd_ff  <= csr_data;
               CSR_TILT_GAIN: tilt_gain_ff <= csr_data;
               CSR_FB_GAIN:   fb_gain_ff   <= csr_data;
               default: ;
            endcase
         end
      end
      roll_ff      <= roll_in;
      sum_ff       <= sum_in;
      tmp_ff       <= tmp_in;
      speed_ff     <= speed_in;
      e_ff         <= e_in;
      i_ff         <= i_in;
      d_ff         <= d_in;
      acc_ff       <= acc_in;
      target_ff    <= target_in;
      cmd_ff       <= cmd_in;
      vq_ff        <= vq_in;
      rsp_left_ff  <= rsp_left_in;
      rsp_right_ff <= rsp_right_in;
      rsp_fwd_ff   <= rsp_fwd_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_left_pwm  = rsp_left_ff;
   assign rsp_right_pwm = rsp_right_ff;
   assign rsp_forward   = rsp_fwd_ff;

   a_one_unit: assert property (@(posedge clock) disable iff (reset)
      !(mul_req.start && div_req.start))
      else $error("multiplier and divider started together");

   a_integ_bound: assert property (@(posedge clock) disable iff (reset)
      DW'(angle_integ_ff) <= INTEG_HI && DW'(angle_integ_ff) >= INTEG_LO &&
      DW'(speed_integ_ff) <= INTEG_HI && DW'(speed_integ_ff) >= INTEG_LO)
      else $error("integral outside its clamp");

   a_load_valid: assert property (@(posedge clock) disable iff (reset)
      load |=> rsp_valid_ff && state_ff == ST_IDLE)
      else $error("finished item not presented");

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WAIT) |-> req_stall)
      else $error("input taken while computing");

endmodule

`default_nettype wire
